@@ hw/rtl/gbn_pkg.sv @@
// Shared types, constants and the ack header check for the Go-Back-N sender window.
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int PACKET_BYTES = 4096;
  localparam int PB_BITS      = $clog2(PACKET_BYTES);
  localparam int LEN_W        = 24;
  localparam int CNT_W        = LEN_W - PB_BITS + 1;
  localparam int WIN_W        = 4;
  localparam int TMR_W        = 16;
  localparam int BCNT_W       = 13;
  localparam int SEQ_W        = 8;
  localparam int IDX_W        = 12;
  localparam int WINDOW_MAX   = 8;
  localparam int WINDOW_MIN   = 2;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(8);
  localparam logic [TMR_W-1:0] TIMEOUT_RESET = TMR_W'(500);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_ACK   = 2'd2
  } op_t;

  typedef enum logic {
    KIND_SEND     = 1'b0,
    KIND_COMPLETE = 1'b1
  } kind_t;

  typedef enum logic {
    REG_WINDOW  = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[16]) begin
      return s[15:0] + 16'd1;
    end
    return s[15:0];
  endfunction

  function automatic logic hdr_ok(input logic [15:0] sum_w, input logic [15:0] size_w,
                                  input logic [7:0] flag_b, input logic [7:0] seq_b);
    logic [15:0] acc;
    acc = oc_add(sum_w, size_w);
    acc = oc_add(acc, {seq_b, flag_b});
    return acc == 16'hFFFF;
  endfunction

endpackage

@@ hw/rtl/go_back_n_sender_window.sv @@
// Go-Back-N sender window: send scheduling, ack checking, timeout rewind and completion.
// A request is registered on acceptance, and its result in the result register.
// Throughput: one request per cycle unless the result side stalls; the window update
//   is one compare-and-add pass between the input register and the result register.
// Back-pressure on the result side stalls the input only when a result must wait.
// Reset (rst_n low, synchronous): transfer idle, counters zero, window 8, timeout 500.
`timescale 1ns / 1ps

module go_back_n_sender_window
  import gbn_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [LEN_W-1:0]    in_total_bytes,
  input  logic [15:0]         in_ack_sum,
  input  logic [15:0]         in_ack_size,
  input  logic [7:0]          in_ack_flag,
  input  logic [7:0]          in_ack_seq,

  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_kind,
  output logic [SEQ_W-1:0]    out_seq_number,
  output logic [IDX_W-1:0]    out_packet_index,
  output logic [BCNT_W-1:0]   out_byte_count,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                ir_v_r;
  logic [1:0]          ir_op_r;
  logic [LEN_W-1:0]    ir_len_r;
  logic [15:0]         ir_sum_r;
  logic [15:0]         ir_size_r;
  logic [7:0]          ir_flag_r;
  logic [7:0]          ir_seq_r;

  logic                ov_r;
  logic                ok_kind_r;
  logic [SEQ_W-1:0]    o_seq_r;
  logic [IDX_W-1:0]    o_idx_r;
  logic [BCNT_W-1:0]   o_cnt_r;

  logic [WIN_W-1:0]    win_r;
  logic [TMR_W-1:0]    tmo_r;

  logic                active_r,  active_nxt;
  logic [LEN_W-1:0]    len_r,     len_nxt;
  logic [CNT_W-1:0]    total_r,   total_nxt;
  logic [CNT_W-1:0]    acked_r,   acked_nxt;
  logic [CNT_W-1:0]    next_r,    next_nxt;
  logic [TMR_W-1:0]    timer_r,   timer_nxt;

  logic                res_v;
  logic                res_kind;
  logic [SEQ_W-1:0]    res_seq;
  logic [IDX_W-1:0]    res_idx;
  logic [BCNT_W-1:0]   res_cnt;

  logic                adv;
  logic                accept;
  logic                cfg_wr;

  logic [WIN_W-1:0]    win_eff;
  logic [WIN_W-1:0]    win_lim;
  logic [CNT_W-1:0]    outs_pre;
  logic [CNT_W-1:0]    outs_post;
  logic [7:0]          base_seq;
  logic [7:0]          ack_dist;
  logic [LEN_W:0]      len_round;

  assign adv      = ir_v_r && (!ov_r || !out_stall);
  assign in_stall = ir_v_r && !adv;
  assign accept   = in_valid && !in_stall;

  assign out_valid        = ov_r;
  assign out_kind         = ok_kind_r;
  assign out_seq_number   = o_seq_r;
  assign out_packet_index = o_idx_r;
  assign out_byte_count   = o_cnt_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (reg_idx_t'(paddr[2]) == REG_TIMEOUT) ? {16'd0, tmo_r}
                                                        : {{(32-WIN_W){1'b0}}, win_r};

  always_comb begin
    if (win_r < WIN_W'(WINDOW_MIN)) begin
      win_eff = WIN_W'(WINDOW_MIN);
    end else if (win_r > WIN_W'(WINDOW_MAX)) begin
      win_eff = WIN_W'(WINDOW_MAX);
    end else begin
      win_eff = win_r;
    end
  end

  assign win_lim   = win_eff - WIN_W'(1);
  assign outs_pre  = next_r - acked_r;
  assign base_seq  = acked_r[7:0] + 8'hFF;
  assign ack_dist  = ir_seq_r - base_seq;
  assign len_round = {1'b0, ir_len_r} + (LEN_W+1)'(PACKET_BYTES - 1);

  always_comb begin
    active_nxt = active_r;
    len_nxt    = len_r;
    total_nxt  = total_r;
    acked_nxt  = acked_r;
    next_nxt   = next_r;
    timer_nxt  = timer_r;
    res_v      = 1'b0;
    res_kind   = KIND_SEND;
    res_seq    = '0;
    res_idx    = '0;
    res_cnt    = '0;
    outs_post  = '0;

    if (active_r) begin
      if (acked_r >= total_r) begin
        res_v      = 1'b1;
        res_kind   = KIND_COMPLETE;
        active_nxt = 1'b0;
      end else if (next_r < total_r && outs_pre < CNT_W'(win_lim)) begin
        res_v   = 1'b1;
        res_seq = next_r[SEQ_W-1:0];
        res_idx = next_r[IDX_W-1:0];
        if (next_r == total_r - CNT_W'(1) && len_r[PB_BITS-1:0] != '0) begin
          res_cnt = BCNT_W'(len_r[PB_BITS-1:0]);
        end else begin
          res_cnt = BCNT_W'(PACKET_BYTES);
        end
        timer_nxt = '0;
        next_nxt  = next_r + CNT_W'(1);
      end
    end

    unique case (op_t'(ir_op_r))
      OP_START: begin
        len_nxt    = ir_len_r;
        total_nxt  = CNT_W'(len_round >> PB_BITS);
        acked_nxt  = '0;
        next_nxt   = '0;
        timer_nxt  = '0;
        active_nxt = 1'b1;
      end
      OP_TICK: begin
        if (active_nxt) begin
          if (timer_nxt >= tmo_r) begin
            next_nxt = acked_r;
          end
          if (timer_nxt != {TMR_W{1'b1}}) begin
            timer_nxt = timer_nxt + TMR_W'(1);
          end
        end
      end
      OP_ACK: begin
        if (active_nxt) begin
          outs_post = next_nxt - acked_r;
          if (hdr_ok(ir_sum_r, ir_size_r, ir_flag_r, ir_seq_r)) begin
            if (ack_dist != 8'd0 && CNT_W'(ack_dist) <= outs_post) begin
              acked_nxt = acked_r + CNT_W'(ack_dist);
            end
          end else begin
            next_nxt = acked_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_v_r   <= 1'b0;
      ov_r     <= 1'b0;
      win_r    <= WINDOW_RESET;
      tmo_r    <= TIMEOUT_RESET;
      active_r <= 1'b0;
      len_r    <= '0;
      total_r  <= '0;
      acked_r  <= '0;
      next_r   <= '0;
      timer_r  <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[2]))
          REG_WINDOW:  win_r <= pwdata[WIN_W-1:0];
          REG_TIMEOUT: tmo_r <= pwdata[TMR_W-1:0];
        endcase
      end

      if (accept) begin
        ir_v_r <= 1'b1;
      end else if (adv) begin
        ir_v_r <= 1'b0;
      end

      if (adv && res_v) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end

      if (adv) begin
        active_r <= active_nxt;
        len_r    <= len_nxt;
        total_r  <= total_nxt;
        acked_r  <= acked_nxt;
        next_r   <= next_nxt;
        timer_r  <= timer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_op_r   <= in_opcode;
      ir_len_r  <= in_total_bytes;
      ir_sum_r  <= in_ack_sum;
      ir_size_r <= in_ack_size;
      ir_flag_r <= in_ack_flag;
      ir_seq_r  <= in_ack_seq;
    end
    if (adv && res_v) begin
      ok_kind_r <= res_kind;
      o_seq_r   <= res_seq;
      o_idx_r   <= res_idx;
      o_cnt_r   <= res_cnt;
    end
  end

endmodule

@@ hw/rtl/gbn_checker.sv @@
// Port-level checks for the Go-Back-N sender window, bound to the top level.
`timescale 1ns / 1ps

module gbn_checker
  import gbn_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_kind,
  input logic [SEQ_W-1:0]   out_seq_number,
  input logic [IDX_W-1:0]   out_packet_index,
  input logic [BCNT_W-1:0]  out_byte_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_packet_index) && $stable(out_byte_count))
    else $error("result changed while stalled");

  a_complete_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_COMPLETE |->
      out_seq_number == '0 && out_packet_index == '0 && out_byte_count == '0)
    else $error("complete result carries nonzero fields");

  a_send_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SEND |->
      out_seq_number == out_packet_index[SEQ_W-1:0] && out_byte_count != '0 &&
      out_byte_count <= BCNT_W'(PACKET_BYTES))
    else $error("send result fields inconsistent");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_seq_number   (out_seq_number),
  .out_packet_index (out_packet_index),
  .out_byte_count   (out_byte_count)
);
